// ===== src/fkdb_pkg.sv =====
// Package for the fragment key/depth/blend stage: payload types, config and helpers.
`default_nettype none

package fkdb_pkg;

    // Coordinate field width and default coordinate mask width
    localparam int CoordW          = 11;
    localparam int CoordBitsDef    = 11;

    // Config port geometry
    localparam int CfgIndexW       = 3;
    localparam int CfgDataW        = 16;

    // Reset values of the config registers
    localparam logic [7:0] GlobalAlphaReset = 8'd255;

    // Pipeline depth from request accept to result strobe
    localparam int PipeLatency     = 4;

    // Config register indexes
    typedef enum logic [CfgIndexW-1:0] {
        REG_KEY_ENABLE   = 3'd0,
        REG_KEY_COLOR    = 3'd1,
        REG_DEPTH_ENABLE = 3'd2,
        REG_BLEND_ON     = 3'd3,
        REG_GLOBAL_ALPHA = 3'd4
    } t_reg_index;

    // One fragment request
    typedef struct packed {
        logic [CoordW-1:0]  pixel_x;
        logic [CoordW-1:0]  pixel_y;
        logic [15:0]        frag_color;
        logic signed [15:0] frag_depth;
        logic [7:0]         frag_alpha;
        logic [15:0]        dest_color;
        logic signed [15:0] stored_depth;
    } t_request;

    // One write result
    typedef struct packed {
        logic [CoordW-1:0]  out_x;
        logic [CoordW-1:0]  out_y;
        logic               color_write;
        logic [15:0]        color_out;
        logic               depth_write;
        logic signed [15:0] depth_out;
    } t_result;

    // Live configuration
    typedef struct packed {
        logic        key_enable;
        logic [15:0] key_color;
        logic        depth_enable;
        logic        blend_on;
        logic [7:0]  global_alpha;
    } t_cfg;

    // Fragment after the key/depth test stage
    typedef struct packed {
        logic [CoordW-1:0]  x;
        logic [CoordW-1:0]  y;
        logic               color_write;
        logic               depth_write;
        logic signed [15:0] depth_out;
        logic               blend;
        logic [15:0]        src;
        logic [15:0]        dst;
        logic [15:0]        alpha_prod;
    } t_frag;

    // floor(x / 255) for x below 65280, by reciprocal with rounding fix-up
    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [16:0] sum;
        sum = 17'(x) + 17'(x[15:8]) + 17'd1;
        return sum[15:8];
    endfunction

endpackage

`default_nettype wire

// ===== src/fkdb_cfg.sv =====
// Configuration register file for the fragment stage.
`default_nettype none

module fkdb_cfg
    import fkdb_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CfgIndexW-1:0] i_cfg_index,
    input  wire logic [CfgDataW-1:0]  i_cfg_data,
    output t_cfg                      o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    // Register decode; unknown indexes are dropped
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (t_reg_index'(i_cfg_index))
                REG_KEY_ENABLE:   n_cfg.key_enable   = i_cfg_data[0];
                REG_KEY_COLOR:    n_cfg.key_color    = i_cfg_data[15:0];
                REG_DEPTH_ENABLE: n_cfg.depth_enable = i_cfg_data[0];
                REG_BLEND_ON:     n_cfg.blend_on     = i_cfg_data[0];
                REG_GLOBAL_ALPHA: n_cfg.global_alpha = i_cfg_data[7:0];
                default:          n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.key_enable   <= 1'b0;
            r_cfg.key_color    <= 16'd0;
            r_cfg.depth_enable <= 1'b0;
            r_cfg.blend_on     <= 1'b0;
            r_cfg.global_alpha <= GlobalAlphaReset;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ===== src/fkdb_test.sv =====
// First pipeline stage: color key, depth test, coordinate mask, alpha product.
`default_nettype none

module fkdb_test
    import fkdb_pkg::*;
#(
    parameter int COORD_BITS = CoordBitsDef
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_valid,
    input  t_request      i_request,
    input  t_cfg          i_cfg,
    output logic          o_valid,
    output t_frag         o_frag
);

    logic  r_valid;
    t_frag r_frag;
    t_frag n_frag;
    logic  keyed;
    logic  depth_fail;

    // Key and depth decisions
    always_comb begin
        keyed      = i_cfg.key_enable && (i_cfg.key_color == i_request.frag_color);
        depth_fail = i_cfg.depth_enable &&
                     ($signed(i_request.stored_depth) > $signed(i_request.frag_depth));

        n_frag.color_write = !keyed && !depth_fail;
        n_frag.depth_write = !keyed && !depth_fail && i_cfg.depth_enable;
        n_frag.depth_out   = n_frag.depth_write ? i_request.frag_depth : 16'sd0;
        n_frag.blend       = i_cfg.blend_on;
        n_frag.src         = i_request.frag_color;
        n_frag.dst         = i_request.dest_color;
        n_frag.alpha_prod  = 16'(i_cfg.global_alpha) * 16'(i_request.frag_alpha);

        // coordinates keep only the low COORD_BITS bits
        for (int i = 0; i < CoordW; i++) begin
            n_frag.x[i] = i_request.pixel_x[i] & (i < COORD_BITS);
            n_frag.y[i] = i_request.pixel_y[i] & (i < COORD_BITS);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_frag <= n_frag;
    end

    assign o_valid = r_valid;
    assign o_frag  = r_frag;

endmodule

`default_nettype wire

// ===== src/fkdb_blend.sv =====
// Blend pipeline: alpha scale, per-channel mix products, divide by 255 and pack.
`default_nettype none

module fkdb_blend
    import fkdb_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    input  t_frag     i_frag,
    output logic      o_valid,
    output t_result   o_result
);

    // Stage 2: combined alpha
    logic       r_v2;
    t_frag      r_f2;
    logic [7:0] r_alpha;

    // Stage 3: mix sums per channel
    logic        r_v3;
    t_frag       r_f3;
    logic [12:0] r_mix_r;
    logic [13:0] r_mix_g;
    logic [12:0] r_mix_b;

    // Stage 4: output register
    logic    r_v4;
    t_result r_res;

    logic [7:0]  inv_alpha;
    logic [12:0] n_mix_r;
    logic [13:0] n_mix_g;
    logic [12:0] n_mix_b;
    logic [7:0]  blend_r;
    logic [7:0]  blend_g;
    logic [7:0]  blend_b;
    logic [15:0] color_sel;
    t_result     n_res;

    // Valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            r_v2 <= i_valid;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    // Mix products: a*src + (255-a)*dst
    always_comb begin
        inv_alpha = 8'd255 - r_alpha;
        n_mix_r = 13'(13'(r_alpha) * 13'(r_f2.src[15:11]) +
                      13'(inv_alpha) * 13'(r_f2.dst[15:11]));
        n_mix_g = 14'(14'(r_alpha) * 14'(r_f2.src[10:5]) +
                      14'(inv_alpha) * 14'(r_f2.dst[10:5]));
        n_mix_b = 13'(13'(r_alpha) * 13'(r_f2.src[4:0]) +
                      13'(inv_alpha) * 13'(r_f2.dst[4:0]));
    end

    // Divide, pack and select the final color
    always_comb begin
        blend_r = div255(16'(r_mix_r));
        blend_g = div255(16'(r_mix_g));
        blend_b = div255(16'(r_mix_b));
        color_sel = r_f3.blend ? {blend_r[4:0], blend_g[5:0], blend_b[4:0]} : r_f3.src;

        n_res.out_x       = r_f3.x;
        n_res.out_y       = r_f3.y;
        n_res.color_write = r_f3.color_write;
        n_res.color_out   = r_f3.color_write ? color_sel : 16'd0;
        n_res.depth_write = r_f3.depth_write;
        n_res.depth_out   = r_f3.depth_out;
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_f2    <= i_frag;
        r_alpha <= div255(i_frag.alpha_prod);
        r_f3    <= r_f2;
        r_mix_r <= n_mix_r;
        r_mix_g <= n_mix_g;
        r_mix_b <= n_mix_b;
        r_res   <= n_res;
    end

    assign o_valid  = r_v4;
    assign o_result = r_res;

endmodule

`default_nettype wire

// ===== src/fragment_key_depth_blend.sv =====
// Top level of the RGB565 fragment stage: color key, depth test and alpha blend.
`default_nettype none

// Usage:
//   Config: write registers through i_cfg_we / i_cfg_index / i_cfg_data while no
//   request is in flight. Index 0 key enable, 1 key color, 2 depth enable,
//   3 blend enable, 4 global alpha. Other indexes are ignored.
//   Requests: a fragment is taken at every rising edge where start is high and
//   busy is low. busy is never raised, so one fragment per clock is accepted.
//   Results: each request yields exactly one result, shown on o_result for one
//   cycle with o_result_valid high, after it has passed the test stage register
//   and the alpha, mix and output registers of the blend stage.
//   Stages: key/depth test with alpha product, alpha divide, channel mix
//   products, channel divide and pack. Throughput is one fragment per cycle.
//   Rejected fragments still produce a result with both write enables low.
//   Reset (i_rst_n low, synchronous) clears all in-flight requests and restores
//   register defaults (global alpha 255, everything else 0).
//   The receiver cannot stall; results must be taken in the cycle they appear.
module fragment_key_depth_blend
    import fkdb_pkg::*;
#(
    parameter int COORD_BITS = CoordBitsDef
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CfgIndexW-1:0] i_cfg_index,
    input  wire logic [CfgDataW-1:0]  i_cfg_data,
    input  wire logic                 start,
    output logic                      busy,
    input  t_request                  i_request,
    output logic                      o_result_valid,
    output t_result                   o_result
);

    t_cfg  cfg;
    logic  accept;
    logic  s1_valid;
    t_frag s1_frag;

    // Fully pipelined: never back-pressures
    assign busy   = 1'b0;
    assign accept = start && !busy;

    fkdb_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    fkdb_test #(
        .COORD_BITS (COORD_BITS)
    ) u_test (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (accept),
        .i_request (i_request),
        .i_cfg     (cfg),
        .o_valid   (s1_valid),
        .o_frag    (s1_frag)
    );

    fkdb_blend u_blend (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s1_valid),
        .i_frag   (s1_frag),
        .o_valid  (o_result_valid),
        .o_result (o_result)
    );

`ifndef SYNTHESIS
    // every accepted request produces a result after the pipeline latency
    a_req_to_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##4 o_result_valid)
        else $error("accepted request lost in pipeline");

    // no result without a matching request
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> $past(accept, PipeLatency))
        else $error("result without request");

    // depth is only written for fragments that also write color
    a_depth_implies_color: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_result.depth_write) |-> o_result.color_write)
        else $error("depth write on rejected fragment");

    // dropped fragments carry zero color and depth
    a_drop_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && !o_result.color_write) |->
            (o_result.color_out == 16'd0 && o_result.depth_out == 16'sd0))
        else $error("dropped fragment carries data");
`endif

endmodule

`default_nettype wire
